// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfp: same-cycle check failed");
// next-cycle implication
`define SFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfp: next-cycle check failed");
`else
`define SFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types, constants and helpers of the sample frame packer
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned QB_W       = 29;
    localparam int unsigned US_W       = 20;
    localparam int unsigned FS_W       = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 29;
    localparam int unsigned WCNT_W     = 6;

    // words one item may deliver at most
    localparam int unsigned RESULT_LIMIT = 40;

    localparam logic [WORD_W-1:0] SYNC_WORD         = 32'h5250_5346;
    localparam logic [QB_W-1:0]   HEADER_BYTES      = 29'd16;
    localparam logic [QB_W-1:0]   CAP_FLOOR         = 29'd65536;
    localparam logic [QB_W-1:0]   CAP_CEILING       = 29'd268435456;
    localparam logic [US_W-1:0]   US_CEILING        = 20'd1000000;
    localparam logic [US_W-1:0]   COALESCE_DEFAULT  = 20'd5000;
    localparam logic [US_W-1:0]   KEEPALIVE_DEFAULT = 20'd500000;

    localparam logic [FS_W-1:0]   MFS_RESET = 6'd32;
    localparam logic [QB_W-1:0]   CAP_RESET = 29'd16777216;

    typedef enum logic [1:0] {
        MODE_SAMPLE,
        MODE_TICK,
        MODE_LOSS,
        MODE_DRAIN
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FRAME,
        CFG_COALESCE,
        CFG_KEEPALIVE,
        CFG_RING_CAP
    } t_cfg_idx;

    typedef enum logic [2:0] {
        W_MAGIC,
        W_SEQ,
        W_GAP,
        W_CNT,
        W_PAY
    } t_word_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_STAGE,
        ST_LOSS,
        ST_CHK1,
        ST_CHK2,
        ST_CHK3,
        ST_FLUSH,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_PAY
    } t_state;

    typedef struct packed {
        logic      accept;
        logic      time_inc;
        logic      stage;
        logic      loss_add;
        logic      drain;
        logic      flush;
        logic      ka;
        logic      put;
        logic      adv;
        t_word_sel word_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  chk1;
        logic  lost_nz;
        logic  ka_ok;
        logic  nop;
        logic  frame_ok;
        logic  put_ok;
        logic  fn_zero;
        logic  pay_last;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? '1 : s[WORD_W-1:0];
    endfunction

    function automatic logic [US_W-1:0] eff_us(input logic [US_W-1:0] v,
                                               input logic [US_W-1:0] dflt);
        logic [US_W-1:0] r;
        if (v == '0) begin
            r = dflt;
        end else if (v > US_CEILING) begin
            r = US_CEILING;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sfp_ifs.sv =====
// ----------------------------------------------------------------------------
// sfp channel interfaces
// input item, frame word and config write channels
// ----------------------------------------------------------------------------
interface sfp_in_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [WORD_W-1:0] sample_value;
    logic [WORD_W-1:0] amount;

    modport source (output valid, mode, sample_value, amount, input ready);
    modport sink   (input valid, mode, sample_value, amount, output ready);
endinterface

interface sfp_out_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] frame_word;
    logic              is_header;
    logic              last_of_frame;

    modport source (output valid, frame_word, is_header, last_of_frame, input ready);
    modport sink   (input valid, frame_word, is_header, last_of_frame, output ready);
endinterface

interface sfp_cfg_if import sfp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sfp_dp.sv =====
// ----------------------------------------------------------------------------
// sfp_dp
// datapath: config, counters, stage store, queue accounting and word register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfp_dp import sfp_pkg::*; #(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [1:0]               i_mode,
    input  logic signed [WORD_W-1:0] i_sample,
    input  logic [WORD_W-1:0]        i_amount,
    sfp_out_if.source                o_out,
    sfp_cfg_if.sink                  i_cfg
);

    localparam int unsigned CW    = $clog2(MAX_FRAME + 1);
    localparam int unsigned AW    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int unsigned QBX_W = QB_W + 1;

    // config registers
    logic [FS_W-1:0]   r_cfg_mfs;
    logic [US_W-1:0]   r_cfg_coal;
    logic [US_W-1:0]   r_cfg_ka;
    logic [QB_W-1:0]   r_cfg_cap;

    // item registers
    logic [1:0]        r_mode;
    logic [WORD_W-1:0] r_sample;
    logic [WORD_W-1:0] r_amount;

    // block state
    logic [CW-1:0]     r_count;
    logic [WORD_W-1:0] r_start;
    logic [WORD_W-1:0] r_lost;
    logic [WORD_W-1:0] r_seq;
    logic [QB_W-1:0]   r_queued;
    logic [WORD_W-1:0] r_time;
    logic [WORD_W-1:0] r_last_act;

    // frame in flight
    logic [CW-1:0]     r_fn;
    logic [WORD_W-1:0] r_gap;
    logic [CW-1:0]     r_idx;
    logic [WCNT_W-1:0] r_wcnt;

    // stage store
    logic [WORD_W-1:0] r_mem [MAX_FRAME];
    logic [WORD_W-1:0] r_rd_data;
    logic [AW-1:0]     w_rd_addr;

    // output word register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_hdr;
    logic              r_out_last;

    logic [CW-1:0]     w_fs;
    logic [US_W-1:0]   w_coal;
    logic [US_W-1:0]   w_ka_lim;
    logic [QB_W-1:0]   w_cap;
    logic [QBX_W-1:0]  w_flen;
    logic [QBX_W-1:0]  w_q_plus;
    logic [WORD_W-1:0] w_elapsed;
    logic [WORD_W-1:0] w_idle;
    logic              w_suppress;
    logic              w_step;
    logic              w_emit;
    logic [WORD_W-1:0] w_word;
    logic              w_hdr;
    logic              w_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mfs  <= MFS_RESET;
            r_cfg_coal <= COALESCE_DEFAULT;
            r_cfg_ka   <= KEEPALIVE_DEFAULT;
            r_cfg_cap  <= CAP_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MAX_FRAME: r_cfg_mfs  <= i_cfg.data[FS_W-1:0];
                CFG_COALESCE:  r_cfg_coal <= i_cfg.data[US_W-1:0];
                CFG_KEEPALIVE: r_cfg_ka   <= i_cfg.data[US_W-1:0];
                CFG_RING_CAP:  r_cfg_cap  <= i_cfg.data[QB_W-1:0];
                default: ;
            endcase
        end
    end

    // effective register values
    always_comb begin
        if (r_cfg_mfs == '0) begin
            w_fs = CW'(1);
        end else if ({1'b0, r_cfg_mfs} > (FS_W + 1)'(MAX_FRAME)) begin
            w_fs = CW'(MAX_FRAME);
        end else begin
            w_fs = CW'(r_cfg_mfs);
        end
        if (r_cfg_cap < CAP_FLOOR) begin
            w_cap = CAP_FLOOR;
        end else if (r_cfg_cap > CAP_CEILING) begin
            w_cap = CAP_CEILING;
        end else begin
            w_cap = r_cfg_cap;
        end
    end

    assign w_coal    = eff_us(r_cfg_coal, COALESCE_DEFAULT);
    assign w_ka_lim  = eff_us(r_cfg_ka, KEEPALIVE_DEFAULT);
    assign w_flen    = QBX_W'(HEADER_BYTES) + QBX_W'({r_count, 2'b00});
    assign w_q_plus  = {1'b0, r_queued} + w_flen;
    assign w_elapsed = r_time - r_start;
    assign w_idle    = r_time - r_last_act;

    assign w_suppress = (r_wcnt >= WCNT_W'(RESULT_LIMIT));
    assign w_step     = i_cmd.put && (w_suppress || !r_out_valid || o_out.ready);
    assign w_emit     = w_step && !w_suppress;

    always_comb begin
        o_sts.mode     = t_mode'(r_mode);
        o_sts.full     = (r_count >= w_fs);
        o_sts.chk1     = (r_count != '0) && ((r_count >= w_fs) ||
                         (w_elapsed >= WORD_W'(w_coal)));
        o_sts.lost_nz  = (r_lost != '0);
        o_sts.nop      = (r_count == '0) && (r_lost == '0);
        o_sts.ka_ok    = (r_count == '0) && (r_lost == '0) && (r_queued == '0) &&
                         (w_idle >= WORD_W'(w_ka_lim));
        o_sts.frame_ok = (w_q_plus <= {1'b0, w_cap});
        o_sts.put_ok   = w_suppress || !r_out_valid || o_out.ready;
        o_sts.fn_zero  = (r_fn == '0);
        o_sts.pay_last = ((r_idx + CW'(1)) == r_fn);
    end

    // word select
    always_comb begin
        w_word = '0;
        w_hdr  = 1'b1;
        w_last = 1'b0;
        case (i_cmd.word_sel)
            W_MAGIC: w_word = SYNC_WORD;
            W_SEQ:   w_word = r_seq;
            W_GAP:   w_word = r_gap;
            W_CNT: begin
                w_word = WORD_W'(r_fn);
                w_last = (r_fn == '0);
            end
            W_PAY: begin
                w_word = r_rd_data;
                w_hdr  = 1'b0;
                w_last = ((r_idx + CW'(1)) == r_fn);
            end
            default: w_hdr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_mode;
            r_sample <= $unsigned(i_sample);
            r_amount <= i_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_start    <= '0;
            r_lost     <= '0;
            r_seq      <= '0;
            r_queued   <= '0;
            r_time     <= '0;
            r_last_act <= '0;
            r_fn       <= '0;
            r_gap      <= '0;
            r_idx      <= '0;
            r_wcnt     <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_wcnt <= '0;
            end else if (w_emit) begin
                r_wcnt <= r_wcnt + WCNT_W'(1);
            end
            if (i_cmd.time_inc) begin
                r_time <= r_time + WORD_W'(1);
            end
            if (i_cmd.drain) begin
                r_queued <= (r_amount >= WORD_W'(r_queued)) ? '0 :
                            (r_queued - r_amount[QB_W-1:0]);
            end
            if (i_cmd.stage) begin
                if (r_count == '0) begin
                    r_start <= r_time;
                end
                if (r_count < CW'(MAX_FRAME)) begin
                    r_count <= r_count + CW'(1);
                end
                r_last_act <= r_time;
            end
            if (i_cmd.loss_add) begin
                r_lost     <= sat_add(r_lost, r_amount);
                r_last_act <= r_time;
            end
            if (i_cmd.flush && (i_cmd.ka || !o_sts.nop)) begin
                if (o_sts.frame_ok) begin
                    r_queued <= w_q_plus[QB_W-1:0];
                    r_lost   <= '0;
                    r_fn     <= r_count;
                    r_gap    <= r_lost;
                    if (i_cmd.ka) begin
                        r_last_act <= r_time;
                    end
                end else begin
                    r_lost <= sat_add(r_lost, WORD_W'(r_count));
                end
                r_count <= '0;
            end
            if (i_cmd.flush) begin
                r_idx <= '0;
            end else if (i_cmd.adv) begin
                r_idx <= r_idx + CW'(1);
            end
            if (w_step && (i_cmd.word_sel == W_SEQ)) begin
                r_seq <= r_seq + WORD_W'(1);
            end
        end
    end

    // read address runs one word ahead while payload advances
    assign w_rd_addr = i_cmd.flush ? '0 :
                       i_cmd.adv ? AW'(r_idx + CW'(1)) : AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage && (r_count < CW'(MAX_FRAME))) begin
            r_mem[AW'(r_count)] <= r_sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_word <= w_word;
            r_out_hdr  <= w_hdr;
            r_out_last <= w_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.frame_word    = r_out_word;
    assign o_out.is_header     = r_out_hdr;
    assign o_out.last_of_frame = r_out_last;

    `SFP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_FRAME))
    `SFP_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1, r_queued <= CAP_CEILING)
    `SFP_ASSERT_IMP(a_word_limit, i_clk, i_rst_n, 1'b1, r_wcnt <= WCNT_W'(RESULT_LIMIT))
    `SFP_ASSERT_NXT(a_seq_step, i_clk, i_rst_n, w_step && (i_cmd.word_sel == W_SEQ), r_seq == $past(r_seq) + WORD_W'(1))

endmodule

// ===== hw/rtl/sfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfp_ctrl
// controller: walks each item through mode, checks and frame emission
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfp_ctrl import sfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_ka, n_ka;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_ka    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ka    <= n_ka;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_ka       = r_ka;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PRE;
                end
            end
            ST_PRE: begin
                case (i_sts.mode)
                    MODE_SAMPLE: begin
                        if (i_sts.full) begin
                            n_ret   = ST_STAGE;
                            n_ka    = 1'b0;
                            n_state = ST_FLUSH;
                        end else begin
                            n_state = ST_STAGE;
                        end
                    end
                    MODE_TICK: begin
                        o_cmd.time_inc = 1'b1;
                        n_state        = ST_CHK1;
                    end
                    MODE_LOSS: begin
                        n_ret   = ST_LOSS;
                        n_ka    = 1'b0;
                        n_state = ST_FLUSH;
                    end
                    MODE_DRAIN: begin
                        o_cmd.drain = 1'b1;
                        n_state     = ST_CHK1;
                    end
                    default: n_state = ST_CHK1;
                endcase
            end
            ST_STAGE: begin
                o_cmd.stage = 1'b1;
                n_state     = ST_CHK1;
            end
            ST_LOSS: begin
                o_cmd.loss_add = 1'b1;
                n_state        = ST_CHK1;
            end
            ST_CHK1: begin
                if (i_sts.chk1) begin
                    n_ret   = ST_CHK2;
                    n_ka    = 1'b0;
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_CHK2;
                end
            end
            ST_CHK2: begin
                if (i_sts.lost_nz) begin
                    n_ret   = ST_CHK3;
                    n_ka    = 1'b0;
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_CHK3;
                end
            end
            ST_CHK3: begin
                if ((i_sts.mode == MODE_TICK || i_sts.mode == MODE_DRAIN) && i_sts.ka_ok) begin
                    n_ret   = ST_IDLE;
                    n_ka    = 1'b1;
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                o_cmd.ka    = r_ka;
                if (!r_ka && i_sts.nop) begin
                    n_state = r_ret;
                end else if (i_sts.frame_ok) begin
                    n_state = ST_H0;
                end else begin
                    n_state = r_ret;
                end
            end
            ST_H0: begin
                o_cmd.put      = 1'b1;
                o_cmd.word_sel = W_MAGIC;
                if (i_sts.put_ok) begin
                    n_state = ST_H1;
                end
            end
            ST_H1: begin
                o_cmd.put      = 1'b1;
                o_cmd.word_sel = W_SEQ;
                if (i_sts.put_ok) begin
                    n_state = ST_H2;
                end
            end
            ST_H2: begin
                o_cmd.put      = 1'b1;
                o_cmd.word_sel = W_GAP;
                if (i_sts.put_ok) begin
                    n_state = ST_H3;
                end
            end
            ST_H3: begin
                o_cmd.put      = 1'b1;
                o_cmd.word_sel = W_CNT;
                if (i_sts.put_ok) begin
                    n_state = i_sts.fn_zero ? r_ret : ST_PAY;
                end
            end
            ST_PAY: begin
                o_cmd.put      = 1'b1;
                o_cmd.word_sel = W_PAY;
                o_cmd.adv      = i_sts.put_ok;
                if (i_sts.put_ok && i_sts.pay_last) begin
                    n_state = r_ret;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `SFP_ASSERT_IMP(a_pay_nonempty, i_clk, i_rst_n, r_state == ST_PAY, !i_sts.fn_zero)
    `SFP_ASSERT_NXT(a_no_frame_without_room, i_clk, i_rst_n, (r_state == ST_FLUSH) && !i_sts.frame_ok, r_state != ST_H0)
    `SFP_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, (r_state == ST_IDLE) && i_in_valid, r_state == ST_PRE)

endmodule

// ===== hw/rtl/sample_frame_packer_with_gap_report_core.sv =====
// ----------------------------------------------------------------------------
// sample_frame_packer_with_gap_report_core
// packs samples into magic/sequence/gap/count framed words with loss reporting
// ----------------------------------------------------------------------------
// one item is handled at a time. a tick or drain that sends no frame steps
// through accept, mode update and three checks, a sample adds the staging
// step and a loss adds its stage flush attempt and the loss update; every
// further frame attempt adds a flush step, and a frame that fits the queue
// adds 4 header words and its payload words, more while the word output
// stalls. a sample that finds the stage full pays for that extra frame too.
// the controller steps through each check in turn, and the stage store,
// which has one write and one read port, feeds one payload word a cycle
// while the word output does not stall.
// the stage store is not cleared at reset and no slot is sent before it is
// written. at most 40 words are delivered per item; further words of that
// item are dropped while the queue and sequence still account for them.
// config writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
module sample_frame_packer_with_gap_report_core import sfp_pkg::*; #(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfp_in_if.sink    i_in,
    sfp_out_if.source o_out,
    sfp_cfg_if.sink   i_cfg
);

    // controller to datapath command and status bundles
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // sequencing: mode update, coalesce and loss checks, keepalive, frame out
    sfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // ready only between items
    assign i_in.ready = w_in_ready;

    // state, stage store, queue accounting and the registered word output
    sfp_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_mode   (i_in.mode),
        .i_sample (i_in.sample_value),
        .i_amount (i_in.amount),
        .o_out    (o_out),
        .i_cfg    (i_cfg)
    );

endmodule
